// ----- hdl/vls_pkg.sv -----
// ---------------------------------------------------------------------------
// vls_pkg
// Shared types and constants for the two-dimensional vector length set block.
// ---------------------------------------------------------------------------
package vls_pkg;

    localparam int CW        = 32;   // coordinate width, Q16.16
    localparam int FRAC_BITS = 16;
    localparam int THR_W     = 16;   // near-zero threshold register width
    localparam int PW        = 2 * CW;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef struct packed {
        logic signed [CW-1:0] vec_x;
        logic signed [CW-1:0] vec_y;
        logic        [CW-1:0] target_length;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic        [CW-1:0] own_length;
        logic                 ok;
    } out_item_t;

    // data that rides alongside the square root pipeline
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] t;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
    } sqrt_side_t;

    // data that rides alongside the divider pipeline
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] len;
        logic          ok;
    } div_side_t;

endpackage

// ----- hdl/vls_sqrt.sv -----
// ---------------------------------------------------------------------------
// vls_sqrt
// Pipelined digit-by-digit square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module vls_sqrt (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [vls_pkg::PW-1:0]  rad,
    input  vls_pkg::sqrt_side_t     in_side,
    output logic                    out_valid,
    output logic [vls_pkg::CW-1:0]  root,
    output logic [vls_pkg::CW+2:0]  rem,
    output vls_pkg::sqrt_side_t     out_side
);
    localparam int STEPS = vls_pkg::CW;
    localparam int REM_W = vls_pkg::CW + 3;

    logic [REM_W-1:0]         rem_reg   [STEPS];
    logic [vls_pkg::CW-1:0]   root_reg  [STEPS];
    logic [vls_pkg::PW-1:0]   rad_reg   [STEPS];
    logic                     valid_reg [STEPS];
    vls_pkg::sqrt_side_t      side_reg  [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [REM_W-1:0]       rem_in;
        logic [REM_W-1:0]       rem_sh;
        logic [REM_W-1:0]       trial;
        logic [vls_pkg::CW-1:0] root_in;
        logic [vls_pkg::PW-1:0] rad_in;
        logic                   valid_in;
        vls_pkg::sqrt_side_t    side_in;
        logic                   take;

        if (i == 0) begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = rad;
            assign valid_in = in_valid;
            assign side_in  = in_side;
        end else begin : g_next
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign rad_in   = rad_reg[i-1];
            assign valid_in = valid_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[vls_pkg::PW-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_in[vls_pkg::CW-2:0], take};
                rad_reg[i]  <= {rad_in[vls_pkg::PW-3:0], 2'b00};
                side_reg[i] <= side_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign rem       = rem_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hdl/vls_div.sv -----
// ---------------------------------------------------------------------------
// vls_div
// Two-lane pipelined restoring divider with a shared divisor; an entry stage
// flags quotients that do not fit, then one quotient bit per stage.
// ---------------------------------------------------------------------------
module vls_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [vls_pkg::PW-1:0]  num_x,
    input  logic [vls_pkg::PW-1:0]  num_y,
    input  vls_pkg::div_side_t      in_side,
    output logic                    out_valid,
    output logic [vls_pkg::CW-1:0]  quo_x,
    output logic [vls_pkg::CW-1:0]  quo_y,
    output logic                    ovf_x,
    output logic                    ovf_y,
    output vls_pkg::div_side_t      out_side
);
    localparam int STEPS = vls_pkg::CW;
    localparam int CW    = vls_pkg::CW;

    // index 0 is the entry stage
    logic [CW-1:0]       rem_reg   [STEPS+1][2];
    logic [CW-1:0]       num_reg   [STEPS+1][2];
    logic [CW-1:0]       quo_reg   [STEPS+1][2];
    logic                ovf_reg   [STEPS+1][2];
    logic                valid_reg [STEPS+1];
    vls_pkg::div_side_t  side_reg  [STEPS+1];

    logic [CW-1:0] hi_x;
    logic [CW-1:0] hi_y;
    logic          big_x;
    logic          big_y;

    assign hi_x  = num_x[vls_pkg::PW-1:CW];
    assign hi_y  = num_y[vls_pkg::PW-1:CW];
    assign big_x = (hi_x >= in_side.len);
    assign big_y = (hi_y >= in_side.len);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0][0] <= big_x ? '0 : hi_x;
            rem_reg[0][1] <= big_y ? '0 : hi_y;
            num_reg[0][0] <= num_x[CW-1:0];
            num_reg[0][1] <= num_y[CW-1:0];
            quo_reg[0][0] <= '0;
            quo_reg[0][1] <= '0;
            ovf_reg[0][0] <= big_x;
            ovf_reg[0][1] <= big_y;
            side_reg[0]   <= in_side;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [CW:0] part;
            logic        take;

            assign part = {rem_reg[k-1][l], num_reg[k-1][l][CW-1]};
            assign take = (part >= {1'b0, side_reg[k-1].len});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l] <= take ? CW'(part - {1'b0, side_reg[k-1].len})
                                          : part[CW-1:0];
                    num_reg[k][l] <= {num_reg[k-1][l][CW-2:0], 1'b0};
                    quo_reg[k][l] <= {quo_reg[k-1][l][CW-2:0], take};
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign quo_x     = quo_reg[STEPS][0];
    assign quo_y     = quo_reg[STEPS][1];
    assign ovf_x     = ovf_reg[STEPS][0];
    assign ovf_y     = ovf_reg[STEPS][1];
    assign out_side  = side_reg[STEPS];

endmodule

// ----- hdl/vector2_length_set.sv -----
// ---------------------------------------------------------------------------
// vector2_length_set
// Scales a signed Q16.16 vector to a wanted length, reporting its own length.
// ---------------------------------------------------------------------------
// One item enters per clock and one result leaves per clock when the output
// side keeps up. The registered steps are the magnitudes, multipliers, sum,
// one square root stage per length bit, rounding and numerator, one divider
// stage per quotient bit plus its entry, and saturation of the result.
// The whole pipeline holds while a result waits and the output side is not
// ready, so s_ready follows m_ready whenever the output register is full.
// The length is sqrt(x*x + y*y) rounded to nearest. If it, or the wanted
// length, is at or below near_zero_threshold the vector is returned as is and
// ok is low; otherwise each component becomes component * wanted / length,
// rounded half away from zero and saturated to the signed range.
// ---------------------------------------------------------------------------
module vector2_length_set (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [vls_pkg::THR_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  vls_pkg::in_item_t           s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output vls_pkg::out_item_t          m_item
);
    localparam int CW = vls_pkg::CW;
    localparam int PW = vls_pkg::PW;

    logic en;

    logic [vls_pkg::THR_W-1:0] thr_reg;

    // stage A: magnitudes
    logic          a_valid_reg;
    logic [CW-1:0] a_x_reg, a_y_reg, a_t_reg, a_mx_reg, a_my_reg;
    // stage B: products
    logic          b_valid_reg;
    logic [CW-1:0] b_x_reg, b_y_reg, b_t_reg;
    logic [PW-1:0] b_sx_reg, b_sy_reg, b_px_reg, b_py_reg;
    // stage C: sum of squares
    logic                c_valid_reg;
    logic [PW-1:0]       c_sum_reg;
    vls_pkg::sqrt_side_t c_side_reg;

    logic                sq_valid;
    logic [CW-1:0]       sq_root;
    logic [CW+2:0]       sq_rem;
    vls_pkg::sqrt_side_t sq_side;

    // stage D: rounded length and decision
    logic                d_valid_reg;
    logic [CW-1:0]       d_len_reg;
    logic                d_ok_reg;
    vls_pkg::sqrt_side_t d_side_reg;
    logic [CW-1:0]       d_len_next;
    // stage E: rounded numerators
    logic                e_valid_reg;
    logic [PW-1:0]       e_nx_reg, e_ny_reg;
    vls_pkg::div_side_t  e_side_reg;

    logic                dv_valid;
    logic [CW-1:0]       dv_qx, dv_qy;
    logic                dv_ovx, dv_ovy;
    vls_pkg::div_side_t  dv_side;

    logic                m_valid_reg;
    vls_pkg::out_item_t  m_item_reg;
    vls_pkg::out_item_t  m_item_next;

    // advance everything unless a result sits unaccepted
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= vls_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
        // most negative value keeps its magnitude as the sign bit alone
        return v[CW-1] ? CW'(~v + CW'(1)) : v;
    endfunction

    function automatic logic [CW-1:0] sat(input logic [CW-1:0] q,
                                          input logic ovf, input logic neg);
        logic [CW-1:0] lim;
        lim = {1'b0, {(CW-1){1'b1}}};
        if (neg) begin
            return (ovf || q[CW-1]) ? {1'b1, {(CW-1){1'b0}}} : CW'(~q + CW'(1));
        end
        return (ovf || q > lim) ? lim : q;
    endfunction

    // valid bits of the stages outside the square root and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= sq_valid;
            e_valid_reg <= d_valid_reg;
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg  <= s_item.vec_x;
            a_y_reg  <= s_item.vec_y;
            a_t_reg  <= s_item.target_length;
            a_mx_reg <= mag(s_item.vec_x);
            a_my_reg <= mag(s_item.vec_y);

            b_x_reg  <= a_x_reg;
            b_y_reg  <= a_y_reg;
            b_t_reg  <= a_t_reg;
            b_sx_reg <= PW'(a_mx_reg) * PW'(a_mx_reg);
            b_sy_reg <= PW'(a_my_reg) * PW'(a_my_reg);
            b_px_reg <= PW'(a_mx_reg) * PW'(a_t_reg);
            b_py_reg <= PW'(a_my_reg) * PW'(a_t_reg);

            c_sum_reg     <= b_sx_reg + b_sy_reg;
            c_side_reg.x  <= b_x_reg;
            c_side_reg.y  <= b_y_reg;
            c_side_reg.t  <= b_t_reg;
            c_side_reg.px <= b_px_reg;
            c_side_reg.py <= b_py_reg;
        end
    end

    vls_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .rad       (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .rem       (sq_rem),
        .out_side  (sq_side)
    );

    // round to nearest: step up when the remainder exceeds the root
    assign d_len_next = sq_root + CW'(sq_rem > (CW+3)'(sq_root));

    always_ff @(posedge aclk) begin
        if (en) begin
            d_len_reg  <= d_len_next;
            d_ok_reg   <= (d_len_next > CW'(thr_reg)) && (sq_side.t > CW'(thr_reg));
            d_side_reg <= sq_side;

            e_nx_reg       <= d_side_reg.px + PW'(d_len_reg[CW-1:1]);
            e_ny_reg       <= d_side_reg.py + PW'(d_len_reg[CW-1:1]);
            e_side_reg.x   <= d_side_reg.x;
            e_side_reg.y   <= d_side_reg.y;
            e_side_reg.ok  <= d_ok_reg;
            // a failed item may carry a zero divisor; its quotient is dropped
            e_side_reg.len <= d_len_reg;
        end
    end

    vls_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num_x     (e_nx_reg),
        .num_y     (e_ny_reg),
        .in_side   (e_side_reg),
        .out_valid (dv_valid),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .ovf_x     (dv_ovx),
        .ovf_y     (dv_ovy),
        .out_side  (dv_side)
    );

    // saturate, or pass the input through on failure
    always_comb begin
        m_item_next.own_length = dv_side.len;
        m_item_next.ok         = dv_side.ok;
        if (dv_side.ok) begin
            m_item_next.out_x = sat(dv_qx, dv_ovx, dv_side.x[CW-1]);
            m_item_next.out_y = sat(dv_qy, dv_ovy, dv_side.y[CW-1]);
        end else begin
            m_item_next.out_x = dv_side.x;
            m_item_next.out_y = dv_side.y;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- hdl/vls_checker.sv -----
// ---------------------------------------------------------------------------
// vls_props
// Port-level checks for the vector length set block, bound to the top level.
// ---------------------------------------------------------------------------
module vls_props (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input vls_pkg::out_item_t        m_item
);
    // hold a waiting result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    a_s_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a scaled result always has a non-zero own length
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.ok |-> m_item.own_length != '0)
        else $error("ok with zero length");

    // nothing leaves straight after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result right after reset");

endmodule

bind vector2_length_set vls_props u_vls_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ----- dv/vls_checker.sv -----
// ---------------------------------------------------------------------------
// vls_checker
// Watches both channels of the vector length set block, predicts each result
// from the accepted input item and compares it field by field.
// ---------------------------------------------------------------------------
module vls_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [vls_pkg::THR_W-1:0] cfg_wr_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  vls_pkg::in_item_t      s_item,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  vls_pkg::out_item_t     m_item,
    output int                     fail_count,
    output int                     pending_count
);
    localparam int CW    = vls_pkg::CW;
    localparam int PW    = vls_pkg::PW;
    localparam int THR_W = vls_pkg::THR_W;

    logic [THR_W-1:0]    threshold;
    vls_pkg::out_item_t  expected_q[$];

    // Rounded square root of a 65-bit sum of squares.
    function automatic logic [CW-1:0] root_round(logic [PW:0] s);
        logic [PW:0] r;
        logic [PW:0] c;
        logic [2*PW+1:0] sq;
        r = '0;
        for (int b = CW; b >= 0; b--) begin
            c  = r | ((PW+1)'(1) << b);
            sq = c * c;
            if (sq <= {{(PW+1){1'b0}}, s}) begin
                r = c;
            end
        end
        // round up when the remainder exceeds r
        if (s - r * r > r) begin
            r = r + 1;
        end
        return r[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] rescale(logic [CW-1:0] v, logic [CW-1:0] t,
                                              logic [CW-1:0] len);
        logic          neg;
        logic [CW-1:0] mag;
        logic [PW+1:0] q;
        neg = v[CW-1];
        mag = neg ? -v : v;
        q   = ({2'b0, PW'(mag) * PW'(t)} + (PW+2)'(len >> 1)) / (PW+2)'(len);
        if (neg) begin
            if (q >= (PW+2)'(1) << (CW-1)) begin
                return {1'b1, {(CW-1){1'b0}}};
            end
            return -q[CW-1:0];
        end
        if (q > (PW+2)'({1'b0, {(CW-1){1'b1}}})) begin
            return {1'b0, {(CW-1){1'b1}}};
        end
        return q[CW-1:0];
    endfunction

    function automatic vls_pkg::out_item_t predict_length_set(vls_pkg::in_item_t it,
                                                              logic [THR_W-1:0] thr);
        vls_pkg::out_item_t r;
        logic [CW-1:0]      mx;
        logic [CW-1:0]      my;
        logic [PW:0]        sum;
        mx  = it.vec_x[CW-1] ? -it.vec_x : it.vec_x;
        my  = it.vec_y[CW-1] ? -it.vec_y : it.vec_y;
        sum = (PW+1)'(PW'(mx) * PW'(mx)) + (PW+1)'(PW'(my) * PW'(my));
        r.own_length = root_round(sum);
        if (r.own_length <= CW'(thr) || it.target_length <= CW'(thr)) begin
            r.out_x = it.vec_x;
            r.out_y = it.vec_y;
            r.ok    = 1'b0;
        end else begin
            r.out_x = rescale(it.vec_x, it.target_length, r.own_length);
            r.out_y = rescale(it.vec_y, it.target_length, r.own_length);
            r.ok    = 1'b1;
        end
        return r;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge aclk) begin
        vls_pkg::out_item_t exp_item;
        if (!aresetn) begin
            threshold  <= vls_pkg::THR_RESET;
            fail_count <= 0;
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                threshold <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_length_set(s_item, threshold));
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result %p", m_item);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (m_item.out_x !== exp_item.out_x || m_item.out_y !== exp_item.out_y ||
                        m_item.own_length !== exp_item.own_length ||
                        m_item.ok !== exp_item.ok) begin
                        if (fail_count < 10) begin
                            $display("mismatch: expected %p got %p", exp_item, m_item);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives the vector length set block with directed and random vectors across
// several threshold settings; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
    localparam int CW          = vls_pkg::CW;
    localparam int THR_W       = vls_pkg::THR_W;
    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 1000000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [THR_W-1:0]   cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    vls_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready;
    vls_pkg::out_item_t m_item;
    int                 fail_count;
    int                 pending_count;
    int                 cycle_count;
    bit                 long_hold;   // ask the receiver for one long hold-off

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    vector2_length_set i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    vls_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // Random coordinate: small magnitudes, extremes and full-range words.
    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return CW'($urandom_range(0, 8)) - CW'(4);
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return CW'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_target();
        case ($urandom_range(0, 4))
            0: return CW'(1) << vls_pkg::FRAC_BITS;     // normalise
            1: return CW'($urandom_range(0, 3));
            2: return {CW{1'b1}};
            3: return CW'($urandom_range(0, 32'h000f_ffff));
            default: return $urandom();
        endcase
    endfunction

    // Offer one item and hold it until accepted; drop valid only for a gap.
    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] t);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_item.vec_x         <= x;
        s_item.vec_y         <= y;
        s_item.target_length <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, wait for the pipeline to drain, then write the threshold.
    task automatic set_threshold(logic [THR_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                stall = gap_cycles();
                if (stall == 0 || $urandom_range(0, 3) == 0) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[vector2_length_set] ERROR");
            $finish;
        end
    end

    initial begin
        logic [THR_W-1:0] thr_set[4];
        logic [CW-1:0]    min_c;
        logic [CW-1:0]    max_c;
        cycle_count = 0;
        long_hold   = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_item      <= '0;
        min_c = {1'b1, {(CW-1){1'b0}}};
        max_c = {1'b0, {(CW-1){1'b1}}};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero vector, unit length, extremes, saturation, threshold edges.
        send_vector('0, '0, 32'h0001_0000);
        send_vector(32'h0003_0000, 32'h0004_0000, 32'h0001_0000);
        send_vector(32'h0003_0000, 32'h0004_0000, '0);
        send_vector(32'h0003_0000, 32'h0004_0000, 32'h1);
        send_vector(32'h0000_0001, '0, 32'h0001_0000);
        send_vector(32'h0000_0002, '0, 32'h0000_0002);
        send_vector(min_c, min_c, {CW{1'b1}});
        send_vector(max_c, max_c, {CW{1'b1}});
        send_vector(min_c, '0, 32'h0001_0000);
        send_vector(max_c, min_c, 32'h0001_0000);
        send_vector(32'h0000_0001, 32'h0000_0001, {CW{1'b1}});
        send_vector(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        send_vector(32'hfffd_0000, 32'h0004_0000, 32'h0005_0000);
        send_vector(32'h0000_0003, 32'hffff_fffc, 32'h0000_0007);

        // Random phases over several thresholds, extremes included.
        thr_set = '{16'h0000, 16'hffff, 16'h0001, 16'h0100};
        foreach (thr_set[p]) begin
            set_threshold(thr_set[p]);
            if (p == 0) begin
                send_vector('0, '0, '0);
                send_vector(32'h0000_0001, '0, 32'h0000_0001);
            end
            if (p == 2) begin
                long_hold = 1'b1;
            end
            for (int n = 0; n < 320; n++) begin
                send_vector(pick_coord(), pick_coord(), pick_target());
            end
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[vector2_length_set] OK");
        end else begin
            $display("[vector2_length_set] ERROR");
        end
        $finish;
    end
endmodule
